@@ sv/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Differential pose controller package
// Shared constants, command types and arithmetic helpers.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int WIN_DEPTH = 32;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

  localparam int PI_Q12          = 12868;
  localparam int TWO_PI_Q12      = 25736;
  localparam int PI_HALF_Q16     = 102944;
  localparam int INV_TWO_PI_Q24  = 2670177;
  localparam int GOAL_MOVE_SQ    = 625;
  localparam int SPIN_SET_SQ     = 900;
  localparam int SPIN_CLR_SQ     = 4900;
  localparam int SQRT_STEPS      = 17;
  localparam int CORDIC_STEPS    = 16;
  localparam int SETUP_STEPS     = 5;
  localparam int MATH_LAST_SPIN  = 3;
  localparam int MATH_LAST_MIX   = 14;

  localparam logic [2:0] REG_GAIN_DISTANCE    = 3'd0;
  localparam logic [2:0] REG_GAIN_HEADING     = 3'd1;
  localparam logic [2:0] REG_GAIN_FINAL_ANGLE = 3'd2;
  localparam logic [2:0] REG_IGAIN_DISTANCE   = 3'd3;
  localparam logic [2:0] REG_IGAIN_HEADING    = 3'd4;
  localparam logic [2:0] REG_IGAIN_FINAL      = 3'd5;
  localparam logic [2:0] REG_SPIN_GAIN        = 3'd6;
  localparam logic [2:0] REG_HALF_TRACK       = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MDX, OP_MDY, OP_MMX, OP_MMY, OP_GOAL, OP_ITER,
    OP_ANG, OP_PUSH, OP_SPIN1, OP_SPIN2,
    OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9, OP_M10,
    OP_M11, OP_M12, OP_M13, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic spin;
  } sts_t;

  typedef struct packed {
    logic [15:0] gain_distance;
    logic [15:0] gain_heading;
    logic [15:0] gain_final_angle;
    logic [15:0] igain_distance;
    logic [15:0] igain_heading;
    logic [15:0] igain_final_angle;
    logic [15:0] spin_gain;
    logic [15:0] half_track;
  } cfg_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] r;
    case (i)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30385;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] d);
    logic signed [17:0] r;
    if (d >= 18'(PI_Q12)) begin
      r = d - 18'(TWO_PI_Q12);
    end else if (d < -18'(PI_Q12)) begin
      r = d + 18'(TWO_PI_Q12);
    end else begin
      r = d;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp30(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > (48'sd1 <<< 30)) begin
      r = 32'sd1 <<< 30;
    end else if (v < -(48'sd1 <<< 30)) begin
      r = -(32'sd1 <<< 30);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/dpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pose controller sequencer
// Walks one pose item through setup, iteration and gain steps.
// ----------------------------------------------------------------------------
module dpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dpc_pkg::sts_t sts_i,
  output dpc_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_ITER  = 3'd2;
  localparam logic [2:0] ST_MATH  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       ovalid_q, ovalid_d;
  logic       emit_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign emit_ok     = !ovalid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    cmd_o.op   = dpc_pkg::OP_NONE;
    cmd_o.idx  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = dpc_pkg::OP_LOAD;
          state_d  = ST_SETUP;
          step_d   = '0;
        end
      end
      ST_SETUP: begin
        case (step_q)
          5'd0:    cmd_o.op = dpc_pkg::OP_MDX;
          5'd1:    cmd_o.op = dpc_pkg::OP_MDY;
          5'd2:    cmd_o.op = dpc_pkg::OP_MMX;
          5'd3:    cmd_o.op = dpc_pkg::OP_MMY;
          default: cmd_o.op = dpc_pkg::OP_GOAL;
        endcase
        step_d = step_q + 5'd1;
        if (step_q == 5'(dpc_pkg::SETUP_STEPS - 1)) begin
          state_d = ST_ITER;
          step_d  = '0;
        end
      end
      ST_ITER: begin
        cmd_o.op = dpc_pkg::OP_ITER;
        step_d   = step_q + 5'd1;
        if (step_q == 5'(dpc_pkg::SQRT_STEPS - 1)) begin
          state_d = ST_MATH;
          step_d  = '0;
        end
      end
      ST_MATH: begin
        case (step_q)
          5'd0:    cmd_o.op = dpc_pkg::OP_ANG;
          5'd1:    cmd_o.op = dpc_pkg::OP_PUSH;
          5'd2:    cmd_o.op = sts_i.spin ? dpc_pkg::OP_SPIN1 : dpc_pkg::OP_M1;
          5'd3:    cmd_o.op = sts_i.spin ? dpc_pkg::OP_SPIN2 : dpc_pkg::OP_M2;
          5'd4:    cmd_o.op = dpc_pkg::OP_M3;
          5'd5:    cmd_o.op = dpc_pkg::OP_M4;
          5'd6:    cmd_o.op = dpc_pkg::OP_M5;
          5'd7:    cmd_o.op = dpc_pkg::OP_M6;
          5'd8:    cmd_o.op = dpc_pkg::OP_M7;
          5'd9:    cmd_o.op = dpc_pkg::OP_M8;
          5'd10:   cmd_o.op = dpc_pkg::OP_M9;
          5'd11:   cmd_o.op = dpc_pkg::OP_M10;
          5'd12:   cmd_o.op = dpc_pkg::OP_M11;
          5'd13:   cmd_o.op = dpc_pkg::OP_M12;
          default: cmd_o.op = dpc_pkg::OP_M13;
        endcase
        step_d = step_q + 5'd1;
        if ((sts_i.spin && step_q == 5'(dpc_pkg::MATH_LAST_SPIN)) ||
            (!sts_i.spin && step_q == 5'(dpc_pkg::MATH_LAST_MIX))) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          cmd_o.op = dpc_pkg::OP_EMIT;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

@@ sv/dpc_dp.sv @@
// ----------------------------------------------------------------------------
// Pose controller datapath
// Shared multiplier, square root and bearing iterations, error windows.
// ----------------------------------------------------------------------------
module dpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpc_pkg::cmd_t       cmd_i,
  input  dpc_pkg::cfg_t       cfg_i,
  input  logic [95:0]         in_data_i,
  output dpc_pkg::sts_t       sts_o,
  output logic signed [15:0]  left_o,
  output logic signed [15:0]  right_o,
  output logic                spin_o
);

  logic signed [16:0] dx_q, dy_q, mx_q, my_q;
  logic signed [14:0] rh_q, gh_q;
  logic [31:0]        goal_q;
  logic [31:0]        last_goal_q;

  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] acc_sum;
  logic [33:0]        rsq_q;

  logic [33:0]        sq_v_q, sq_r_q, sq_bit, sq_try;
  logic signed [34:0] cx_q, cy_q, cx_sh, cy_sh, xs, ys;
  logic signed [19:0] cz_q;
  logic               zero_q;
  logic signed [15:0] brg;

  logic [16:0]        rho_q;
  logic signed [15:0] alpha_q, beta_q, err_q;
  logic               rot_q;

  logic [16:0]        dmem [dpc_pkg::WIN_DEPTH];
  logic [15:0]        hmem [dpc_pkg::WIN_DEPTH];
  logic [15:0]        fmem [dpc_pkg::WIN_DEPTH];
  logic [16:0]        dold_q;
  logic signed [15:0] hold_q, fold_q;
  logic [dpc_pkg::FILL_W-1:0] fill_q;
  logic [dpc_pkg::WIN_AW-1:0] head_q;
  logic               full;

  logic signed [22:0] dsum_q;
  logic signed [21:0] hsum_q, fsum_q;

  logic signed [47:0] a_q, b_q, c_q;
  logic signed [63:0] c_full;
  logic signed [15:0] lres_q, rres_q, spin_s;

  assign sts_o.spin = rot_q;
  assign acc_sum    = acc_q + 64'(prod_q);
  assign full       = (fill_q >= dpc_pkg::FILL_W'(dpc_pkg::WIN_DEPTH));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      dpc_pkg::OP_MDX:   begin mul_a = 32'(dx_q); mul_b = 24'(dx_q); end
      dpc_pkg::OP_MDY:   begin mul_a = 32'(dy_q); mul_b = 24'(dy_q); end
      dpc_pkg::OP_MMX:   begin mul_a = 32'(mx_q); mul_b = 24'(mx_q); end
      dpc_pkg::OP_MMY:   begin mul_a = 32'(my_q); mul_b = 24'(my_q); end
      dpc_pkg::OP_SPIN1: begin
        mul_a = 32'(err_q);
        mul_b = $signed({8'b0, cfg_i.spin_gain});
      end
      dpc_pkg::OP_M1: begin
        mul_a = $signed({15'b0, rho_q});
        mul_b = 24'($signed(cfg_i.gain_distance));
      end
      dpc_pkg::OP_M2: begin
        mul_a = 32'(dsum_q);
        mul_b = 24'($signed(cfg_i.igain_distance));
      end
      dpc_pkg::OP_M3: begin
        mul_a = 32'(alpha_q);
        mul_b = 24'($signed(cfg_i.gain_heading));
      end
      dpc_pkg::OP_M4: begin
        mul_a = 32'(beta_q);
        mul_b = 24'($signed(cfg_i.gain_final_angle));
      end
      dpc_pkg::OP_M5: begin
        mul_a = 32'(hsum_q);
        mul_b = 24'($signed(cfg_i.igain_heading));
      end
      dpc_pkg::OP_M6: begin
        mul_a = 32'(fsum_q);
        mul_b = 24'($signed(cfg_i.igain_final_angle));
      end
      dpc_pkg::OP_M8: begin
        mul_a = 32'(b_q >>> 23);
        mul_b = $signed({8'b0, cfg_i.half_track});
      end
      dpc_pkg::OP_M9: begin
        mul_a = $signed({9'b0, b_q[22:0]});
        mul_b = $signed({8'b0, cfg_i.half_track});
      end
      dpc_pkg::OP_M11: begin
        mul_a = dpc_pkg::clamp30(a_q - c_q);
        mul_b = 24'(dpc_pkg::INV_TWO_PI_Q24);
      end
      dpc_pkg::OP_M12: begin
        mul_a = dpc_pkg::clamp30(a_q + c_q);
        mul_b = 24'(dpc_pkg::INV_TWO_PI_Q24);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_bit = 34'(1) << (6'd32 - {cmd_i.idx, 1'b0});
  assign sq_try = sq_r_q + sq_bit;
  assign cx_sh  = cx_q >>> cmd_i.idx[3:0];
  assign cy_sh  = cy_q >>> cmd_i.idx[3:0];
  assign xs     = 35'(dx_q) <<< 14;
  assign ys     = 35'(dy_q) <<< 14;
  assign brg    = zero_q ? 16'sd0 : 16'((cz_q + 20'sd8) >>> 4);
  assign c_full = ((acc_q <<< 23) + 64'(prod_q) + (64'sd1 <<< 19)) >>> 20;
  assign spin_s = dpc_pkg::sat16((64'(prod_q) + (64'sd1 <<< 19)) >>> 20);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      dpc_pkg::OP_LOAD: begin
        dx_q  <= 17'($signed(in_data_i[62:47])) - 17'($signed(in_data_i[15:0]));
        dy_q  <= 17'($signed(in_data_i[78:63])) - 17'($signed(in_data_i[31:16]));
        mx_q  <= 17'($signed(in_data_i[62:47])) - 17'($signed(last_goal_q[15:0]));
        my_q  <= 17'($signed(in_data_i[78:63])) - 17'($signed(last_goal_q[31:16]));
        rh_q  <= $signed(in_data_i[46:32]);
        gh_q  <= $signed(in_data_i[93:79]);
        goal_q <= in_data_i[78:47];
      end
      dpc_pkg::OP_MDY: acc_q <= 64'(prod_q);
      dpc_pkg::OP_MMX: rsq_q <= acc_sum[33:0];
      dpc_pkg::OP_MMY: acc_q <= 64'(prod_q);
      dpc_pkg::OP_GOAL: begin
        sq_v_q <= rsq_q;
        sq_r_q <= '0;
        zero_q <= (dx_q == 17'sd0) && (dy_q == 17'sd0);
        if (xs < 0) begin
          if (ys >= 0) begin
            cx_q <= ys;
            cy_q <= -xs;
            cz_q <= 20'(dpc_pkg::PI_HALF_Q16);
          end else begin
            cx_q <= -ys;
            cy_q <= xs;
            cz_q <= -20'(dpc_pkg::PI_HALF_Q16);
          end
        end else begin
          cx_q <= xs;
          cy_q <= ys;
          cz_q <= '0;
        end
      end
      dpc_pkg::OP_ITER: begin
        if (sq_v_q >= sq_try) begin
          sq_v_q <= sq_v_q - sq_try;
          sq_r_q <= (sq_r_q >> 1) + sq_bit;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        if (cmd_i.idx < 5'(dpc_pkg::CORDIC_STEPS)) begin
          if (cy_q > 0) begin
            cx_q <= cx_q + cy_sh;
            cy_q <= cy_q - cx_sh;
            cz_q <= cz_q + dpc_pkg::atan_q16(cmd_i.idx[3:0]);
          end else begin
            cx_q <= cx_q - cy_sh;
            cy_q <= cy_q + cx_sh;
            cz_q <= cz_q - dpc_pkg::atan_q16(cmd_i.idx[3:0]);
          end
        end
      end
      dpc_pkg::OP_ANG: begin
        rho_q   <= sq_r_q[16:0];
        alpha_q <= dpc_pkg::wrap_angle(18'(brg) - 18'(rh_q));
        beta_q  <= dpc_pkg::wrap_angle(18'(gh_q) - 18'(brg));
        err_q   <= dpc_pkg::wrap_angle(18'(gh_q) - 18'(rh_q));
      end
      dpc_pkg::OP_SPIN2: begin
        lres_q <= dpc_pkg::sat16(-64'(spin_s));
        rres_q <= spin_s;
      end
      dpc_pkg::OP_M2:  acc_q <= 64'(prod_q);
      dpc_pkg::OP_M3:  a_q <= 48'((acc_sum <<< 4) - acc_sum);
      dpc_pkg::OP_M4:  acc_q <= 64'(prod_q);
      dpc_pkg::OP_M5:  acc_q <= acc_sum;
      dpc_pkg::OP_M6:  acc_q <= acc_sum;
      dpc_pkg::OP_M7:  b_q <= 48'((acc_sum <<< 4) + (acc_sum <<< 2));
      dpc_pkg::OP_M9:  acc_q <= 64'(prod_q);
      dpc_pkg::OP_M10: c_q <= c_full[47:0];
      dpc_pkg::OP_M12: lres_q <= dpc_pkg::sat16((64'(prod_q) + (64'sd1 <<< 31)) >>> 32);
      dpc_pkg::OP_M13: rres_q <= dpc_pkg::sat16((64'(prod_q) + (64'sd1 <<< 31)) >>> 32);
      dpc_pkg::OP_EMIT: begin
        left_o  <= lres_q;
        right_o <= rres_q;
        spin_o  <= rot_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dpc_pkg::OP_ANG) begin
      dold_q <= dmem[head_q];
      hold_q <= hmem[head_q];
      fold_q <= fmem[head_q];
    end
    if (cmd_i.op == dpc_pkg::OP_PUSH) begin
      dmem[head_q] <= rho_q;
      hmem[head_q] <= alpha_q;
      fmem[head_q] <= beta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_goal_q <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      dsum_q      <= '0;
      hsum_q      <= '0;
      fsum_q      <= '0;
      rot_q       <= 1'b0;
    end else begin
      case (cmd_i.op)
        dpc_pkg::OP_GOAL: begin
          if (acc_sum >= 64'(dpc_pkg::GOAL_MOVE_SQ)) begin
            fill_q      <= '0;
            head_q      <= '0;
            dsum_q      <= '0;
            hsum_q      <= '0;
            fsum_q      <= '0;
            last_goal_q <= goal_q;
          end
        end
        dpc_pkg::OP_ANG: begin
          if (rsq_q < 34'(dpc_pkg::SPIN_SET_SQ)) begin
            rot_q <= 1'b1;
          end else if (rsq_q > 34'(dpc_pkg::SPIN_CLR_SQ)) begin
            rot_q <= 1'b0;
          end
        end
        dpc_pkg::OP_PUSH: begin
          dsum_q <= dsum_q + $signed({6'b0, rho_q})
                    - (full ? $signed({6'b0, dold_q}) : 23'sd0);
          hsum_q <= hsum_q + 22'(alpha_q) - (full ? 22'(hold_q) : 22'sd0);
          fsum_q <= fsum_q + 22'(beta_q) - (full ? 22'(fold_q) : 22'sd0);
          if (!full) begin
            fill_q <= fill_q + 1'b1;
          end
          if (head_q == dpc_pkg::WIN_AW'(dpc_pkg::WIN_DEPTH - 1)) begin
            head_q <= '0;
          end else begin
            head_q <= head_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/differential_pose_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Differential pose controller
// Polar pose controller with windowed integral terms and wheel mixing.
// ----------------------------------------------------------------------------
// One pose beat is taken at a time. Its wheel beat passes through the setup
// steps, the 17 square root steps that run alongside the bearing rotations,
// and the gain steps, fewer in rotate-only mode, with the single shared
// multiplier forming every product in turn; it is held back further only
// while an earlier wheel beat still waits on the result side. The input is
// not ready again until the result has moved into the output register, so
// the unit does not take a new pose beat before the last one is through.
module differential_pose_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // robot_x, robot_y, robot_heading, goal_x, goal_y, goal_heading, zero pad
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_speed, right_speed
  output logic [31:0] m_axis_tdata,
  // spinning
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  dpc_pkg::cfg_t cfg_q;
  dpc_pkg::cmd_t cmd;
  dpc_pkg::sts_t sts;
  logic signed [15:0] left_speed, right_speed;
  logic spinning;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {right_speed, left_speed};
  assign m_axis_tuser = spinning;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_distance     <= 16'd256;
      cfg_q.gain_heading      <= 16'd256;
      cfg_q.gain_final_angle  <= 16'd0;
      cfg_q.igain_distance    <= 16'd0;
      cfg_q.igain_heading     <= 16'd0;
      cfg_q.igain_final_angle <= 16'd0;
      cfg_q.spin_gain         <= 16'd256;
      cfg_q.half_track        <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dpc_pkg::REG_GAIN_DISTANCE:    cfg_q.gain_distance     <= cfg_data_i;
        dpc_pkg::REG_GAIN_HEADING:     cfg_q.gain_heading      <= cfg_data_i;
        dpc_pkg::REG_GAIN_FINAL_ANGLE: cfg_q.gain_final_angle  <= cfg_data_i;
        dpc_pkg::REG_IGAIN_DISTANCE:   cfg_q.igain_distance    <= cfg_data_i;
        dpc_pkg::REG_IGAIN_HEADING:    cfg_q.igain_heading     <= cfg_data_i;
        dpc_pkg::REG_IGAIN_FINAL:      cfg_q.igain_final_angle <= cfg_data_i;
        dpc_pkg::REG_SPIN_GAIN:        cfg_q.spin_gain         <= cfg_data_i;
        dpc_pkg::REG_HALF_TRACK:       cfg_q.half_track        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpc_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cfg_i     (cfg_q),
    .in_data_i (s_axis_tdata),
    .sts_o     (sts),
    .left_o    (left_speed),
    .right_o   (right_speed),
    .spin_o    (spinning)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in work");

endmodule

@@ bench/differential_pose_controller_unit_checker.sv @@
// ----------------------------------------------------------------------------
// Differential pose controller checker
// Watches the pose, wheel and register channels. It predicts each wheel beat
// from the pose beats and the register writes, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module differential_pose_controller_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          wheel_beats_o,
  output int          spin_beats_o
);

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               spin;
  } wheel_cmd_t;

  wheel_cmd_t  wheel_buf[8];
  int          put_cnt;
  int          take_cnt;
  logic [15:0] regs[8];
  longint      dist_win[dpc_pkg::WIN_DEPTH];
  longint      head_win[dpc_pkg::WIN_DEPTH];
  longint      fin_win[dpc_pkg::WIN_DEPTH];
  int          fill_cnt;
  int          head_ptr;
  longint      dist_acc;
  longint      head_acc;
  longint      fin_acc;
  logic        spin_mode;
  longint      prev_gx;
  longint      prev_gy;

  assign pending_o = put_cnt - take_cnt;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint wrap_pi(longint d);
    while (d >= dpc_pkg::PI_Q12) d -= dpc_pkg::TWO_PI_Q12;
    while (d < -dpc_pkg::PI_Q12) d += dpc_pkg::TWO_PI_Q12;
    return d;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint goal_bearing(longint dx, longint dy);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint tab[16];
    tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
    if (dx == 0 && dy == 0) return 0;
    x = dx * 16384;
    y = dy * 16384;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; x = nx; z = dpc_pkg::PI_HALF_Q16;
      end else begin
        nx = -y; y = x; x = nx; z = -dpc_pkg::PI_HALF_Q16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += tab[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= tab[i];
      end
      x = nx;
    end
    return round_shift(z, 4);
  endfunction

  function automatic longint wheel_speed(longint num);
    if (num > (64'sd1 <<< 30)) num = 64'sd1 <<< 30;
    if (num < -(64'sd1 <<< 30)) num = -(64'sd1 <<< 30);
    return clip16(round_shift(num * dpc_pkg::INV_TWO_PI_Q24, 32));
  endfunction

  function automatic longint sreg(int i);
    return longint'($signed(regs[i]));
  endfunction

  task automatic predict_wheels(input logic [95:0] d);
    longint rx, ry, rh, gx, gy, gh, dx, dy, rsq, rho, brg;
    longint alpha, beta, serr, mx, my, a, b, c, s;
    int h;
    wheel_cmd_t w;
    rx = longint'($signed(d[15:0]));
    ry = longint'($signed(d[31:16]));
    rh = longint'($signed(d[46:32]));
    gx = longint'($signed(d[62:47]));
    gy = longint'($signed(d[78:63]));
    gh = longint'($signed(d[93:79]));
    dx = gx - rx;
    dy = gy - ry;
    rsq = dx * dx + dy * dy;
    rho = int_sqrt(rsq);
    brg = goal_bearing(dx, dy);
    alpha = wrap_pi(brg - rh);
    beta = wrap_pi(gh - brg);
    serr = wrap_pi(gh - rh);
    mx = gx - prev_gx;
    my = gy - prev_gy;
    if (mx * mx + my * my >= dpc_pkg::GOAL_MOVE_SQ) begin
      fill_cnt = 0;
      head_ptr = 0;
      dist_acc = 0;
      head_acc = 0;
      fin_acc = 0;
      prev_gx = gx;
      prev_gy = gy;
    end
    h = head_ptr;
    if (fill_cnt >= dpc_pkg::WIN_DEPTH) begin
      dist_acc -= dist_win[h];
      head_acc -= head_win[h];
      fin_acc -= fin_win[h];
    end else begin
      fill_cnt++;
    end
    dist_win[h] = rho;
    head_win[h] = alpha;
    fin_win[h] = beta;
    head_ptr = (h + 1) % dpc_pkg::WIN_DEPTH;
    dist_acc += rho;
    head_acc += alpha;
    fin_acc += beta;
    if (rsq < dpc_pkg::SPIN_SET_SQ) spin_mode = 1'b1;
    if (rsq > dpc_pkg::SPIN_CLR_SQ) spin_mode = 1'b0;
    if (spin_mode) begin
      s = clip16(round_shift(longint'(regs[dpc_pkg::REG_SPIN_GAIN]) * serr, 20));
      w.left = 16'(clip16(-s));
      w.right = 16'(s);
    end else begin
      a = 15 * (sreg(dpc_pkg::REG_GAIN_DISTANCE) * rho
                + sreg(dpc_pkg::REG_IGAIN_DISTANCE) * dist_acc);
      b = 20 * (sreg(dpc_pkg::REG_GAIN_HEADING) * alpha
                + sreg(dpc_pkg::REG_GAIN_FINAL_ANGLE) * beta
                + sreg(dpc_pkg::REG_IGAIN_HEADING) * head_acc
                + sreg(dpc_pkg::REG_IGAIN_FINAL) * fin_acc);
      c = round_shift(b * longint'(regs[dpc_pkg::REG_HALF_TRACK]), 20);
      w.left = 16'(wheel_speed(a - c));
      w.right = 16'(wheel_speed(a + c));
    end
    w.spin = spin_mode;
    wheel_buf[put_cnt % 8] = w;
    put_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_cmd_t w;
    if (!rst_ni) begin
      regs = '{256, 256, 0, 0, 0, 0, 256, 256};
      fill_cnt = 0;
      head_ptr = 0;
      dist_acc = 0;
      head_acc = 0;
      fin_acc = 0;
      spin_mode = 1'b0;
      prev_gx = 0;
      prev_gy = 0;
      fail_count_o = 0;
      wheel_beats_o = 0;
      spin_beats_o = 0;
      put_cnt = 0;
      take_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) regs[cfg_index_i] = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (put_cnt == take_cnt) begin
          $error("wheel beat with no pose beat pending");
          fail_count_o++;
        end else begin
          w = wheel_buf[take_cnt % 8];
          take_cnt++;
          wheel_beats_o++;
          if (w.spin) spin_beats_o++;
          if (m_axis_tdata[15:0] !== w.left) begin
            $error("left_speed expected %0d actual %0d", w.left,
                   $signed(m_axis_tdata[15:0]));
            fail_count_o++;
          end
          if (m_axis_tdata[31:16] !== w.right) begin
            $error("right_speed expected %0d actual %0d", w.right,
                   $signed(m_axis_tdata[31:16]));
            fail_count_o++;
          end
          if (m_axis_tuser[0] !== w.spin) begin
            $error("spinning expected %0d actual %0d", w.spin, m_axis_tuser[0]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_wheels(s_axis_tdata);
    end
  end

endmodule

@@ bench/differential_pose_controller_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Differential pose controller testbench
// Drives directed and random pose beats through several register settings
// with random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module differential_pose_controller_unit_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          wheel_beats;
  int          spin_beats;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  logic [15:0] goal_x = 16'd100;
  logic [15:0] goal_y = 16'd100;

  always #6 clk_i = ~clk_i;

  differential_pose_controller_unit DUT (.*);

  differential_pose_controller_unit_checker u_checker (
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .wheel_beats_o(wheel_beats),
    .spin_beats_o (spin_beats),
    .*
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL differential_pose_controller_unit");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 40);
      repeat (n) begin
        @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      if (!quiet) begin
        n = $urandom_range(1, 18);
        repeat (n) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_pose(input logic [15:0] rx, input logic [15:0] ry,
                           input logic [14:0] rh, input logic [15:0] gx,
                           input logic [15:0] gy, input logic [14:0] gh);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk_i);
    s_axis_tdata = {2'b00, gh, gy, gx, rh, ry, rx};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_near(input int span);
    logic [15:0] ox;
    logic [15:0] oy;
    ox = 16'($signed($urandom_range(0, 2 * span)) - span);
    oy = 16'($signed($urandom_range(0, 2 * span)) - span);
    send_pose(goal_x + ox, goal_y + oy, 15'($urandom), goal_x, goal_y, 15'($urandom));
  endtask

  task automatic random_pose();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_pose(16'($urandom), 16'($urandom), 15'($urandom), 16'($urandom),
                16'($urandom), 15'($urandom));
    end else if (r < 18) begin
      goal_x = 16'($urandom);
      goal_y = 16'($urandom);
      send_near(3000);
    end else if (r < 25) begin
      goal_x = goal_x + 16'($urandom_range(0, 40)) - 16'd20;
      send_near(200);
    end else if (r < 55) begin
      send_near(40);
    end else begin
      send_near($urandom_range(60, 4000));
    end
  endtask

  task automatic load_regs(input int setting);
    logic [15:0] v[8];
    for (int i = 0; i < 8; i++) begin
      case (setting)
        1: v[i] = 16'($urandom);
        2: v[i] = 16'h7fff;
        3: v[i] = (i >= dpc_pkg::REG_SPIN_GAIN) ? 16'hffff : 16'h8000;
        4: v[i] = 16'h0000;
        default: v[i] = 16'($signed($urandom_range(0, 1024)) - 512);
      endcase
    end
    while (pending != 0) @(negedge clk_i);
    write_reg(dpc_pkg::REG_GAIN_DISTANCE, v[0]);
    write_reg(dpc_pkg::REG_GAIN_HEADING, v[1]);
    write_reg(dpc_pkg::REG_GAIN_FINAL_ANGLE, v[2]);
    write_reg(dpc_pkg::REG_IGAIN_DISTANCE, v[3]);
    write_reg(dpc_pkg::REG_IGAIN_HEADING, v[4]);
    write_reg(dpc_pkg::REG_IGAIN_FINAL, v[5]);
    write_reg(dpc_pkg::REG_SPIN_GAIN, v[6]);
    write_reg(dpc_pkg::REG_HALF_TRACK, v[7]);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_pose(16'd100, 16'd100, 15'd0, 16'd100, 16'd100, 15'd12868);
    send_pose(16'h8000, 16'h8000, 15'h4000, 16'h7fff, 16'h7fff, 15'h3fff);
    send_pose(16'h7fff, 16'h7fff, 15'h3fff, 16'h8000, 16'h8000, 15'h4000);
    send_pose(16'h8000, 16'h7fff, 15'd12868, 16'h7fff, 16'h8000, -15'sd12868);
    send_pose(16'd0, 16'd0, 15'd0, -16'sd500, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, -16'sd500, -16'sd1, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd0, -16'sd700, 15'd0);
    for (int k = 0; k < 4; k++) begin
      send_pose(16'd0, 16'd0, 15'd0, 16'd24, 16'd0, 15'd100);
      send_pose(16'd0, 16'd0, 15'd0, 16'd30, 16'd0, 15'd100);
    end
    send_pose(16'd0, 16'd0, 15'd0, 16'd49, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd54, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd70, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd71, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd29, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd30, 16'd0, 15'd0);
    send_pose(16'd0, 16'd0, 15'd0, 16'd200, 16'd0, 15'd0);
    goal_x = 16'd100;
    goal_y = 16'd100;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) load_regs((p == 5) ? 0 : p);
      if (p == 5) quiet = 1'b1;
      repeat (65) random_pose();
    end
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Checked %0d wheel beats, %0d of them in rotate-only mode,", wheel_beats,
             spin_beats);
    $display("across six register settings including both signed extremes.");
    if (fail_count == 0) begin
      $display("PASS differential_pose_controller_unit");
    end else begin
      $display("FAIL differential_pose_controller_unit");
    end
    $finish;
  end

endmodule

@@ differential_pose_controller_unit.f @@
sv/dpc_pkg.sv
sv/dpc_ctrl.sv
sv/dpc_dp.sv
sv/differential_pose_controller_unit.sv
bench/differential_pose_controller_unit_checker.sv
bench/differential_pose_controller_unit_tb.sv
